@@ rtl/core/tad_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package tad_pkg;

    localparam int SAMPLE_WIDTH   = 24;
    localparam int DELAY_WIDTH    = 16;
    localparam int TAPS           = 3;
    localparam int SUM_WIDTH      = SAMPLE_WIDTH + 2;
    localparam int APB_ADDR_WIDTH = 5;
    localparam int APB_DATA_WIDTH = 32;

    // register map, word index = paddr[4:2]
    typedef enum logic [2:0] {
        REG_MULTI_MODE   = 3'd0,
        REG_BYPASS       = 3'd1,
        REG_FIRST_DELAY  = 3'd2,
        REG_SECOND_DELAY = 3'd3,
        REG_THIRD_DELAY  = 3'd4
    } reg_idx_t;

    typedef struct packed {
        logic                           channel;
        logic signed [SAMPLE_WIDTH-1:0] sample_in;
    } in_beat_t;

    typedef struct packed {
        logic                           channel_out;
        logic signed [SAMPLE_WIDTH-1:0] sample_out;
    } out_beat_t;

    typedef struct packed {
        logic                      psel;
        logic                      penable;
        logic                      pwrite;
        logic [APB_ADDR_WIDTH-1:0] paddr;
        logic [APB_DATA_WIDTH-1:0] pwdata;
    } apb_req_t;

    typedef struct packed {
        logic multi_mode;
        logic bypass;
    } cfg_t;

    // side information issued alongside the memory reads
    typedef struct packed {
        logic                           channel;
        logic                           in_range;
        logic [TAPS-1:0]                fwd;
        logic [TAPS-1:0]                blank;
        logic signed [SAMPLE_WIDTH-1:0] dry;
    } tap_ctl_t;

endpackage

`default_nettype wire

@@ rtl/core/tad_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module tad_ram #(
    parameter int   WIDTH = 24,
    parameter int   DEPTH = 16,
    localparam int  AW    = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/tad_regs.sv @@
`timescale 1ns / 1ps
`default_nettype none

module tad_regs #(
    parameter int  DELAY_DEPTH = 65536,
    localparam int AW          = $clog2(DELAY_DEPTH)
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire tad_pkg::apb_req_t                     apb,
    output logic [tad_pkg::APB_DATA_WIDTH-1:0]         prdata,
    output tad_pkg::cfg_t                              cfg,
    output logic [tad_pkg::TAPS-1:0][AW-1:0]           tap_delay,
    output logic                                       busy
);

    import tad_pkg::*;

    localparam int         MAX_DELAY     = (1 << DELAY_WIDTH) - 1;
    localparam logic [1:0] SETTLE_CYCLES = 2'd2;

    logic                                 multi_mode_reg;
    logic                                 bypass_reg;
    logic [TAPS-1:0][DELAY_WIDTH-1:0]     delay_reg;
    logic [1:0]                           settle_reg;
    logic                                 wr_en;
    reg_idx_t                             reg_idx;

    assign wr_en   = apb.psel && apb.penable && apb.pwrite;
    assign reg_idx = reg_idx_t'(apb.paddr[APB_ADDR_WIDTH-1:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            multi_mode_reg <= 1'b0;
            bypass_reg     <= 1'b0;
            delay_reg      <= '0;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_MULTI_MODE:   multi_mode_reg <= apb.pwdata[0];
                REG_BYPASS:       bypass_reg     <= apb.pwdata[0];
                REG_FIRST_DELAY:  delay_reg[0]   <= apb.pwdata[DELAY_WIDTH-1:0];
                REG_SECOND_DELAY: delay_reg[1]   <= apb.pwdata[DELAY_WIDTH-1:0];
                REG_THIRD_DELAY:  delay_reg[2]   <= apb.pwdata[DELAY_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    // reduced delays trail the raw ones via prod_reg and rem_reg
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            settle_reg <= SETTLE_CYCLES;
        end else if (wr_en) begin
            settle_reg <= SETTLE_CYCLES;
        end else if (settle_reg != 2'd0) begin
            settle_reg <= settle_reg - 2'd1;
        end
    end

    assign busy           = settle_reg != 2'd0;
    assign cfg.multi_mode = multi_mode_reg;
    assign cfg.bypass     = bypass_reg;

    always_comb begin
        unique case (reg_idx)
            REG_MULTI_MODE:   prdata = APB_DATA_WIDTH'(multi_mode_reg);
            REG_BYPASS:       prdata = APB_DATA_WIDTH'(bypass_reg);
            REG_FIRST_DELAY:  prdata = APB_DATA_WIDTH'(delay_reg[0]);
            REG_SECOND_DELAY: prdata = APB_DATA_WIDTH'(delay_reg[1]);
            REG_THIRD_DELAY:  prdata = APB_DATA_WIDTH'(delay_reg[2]);
            default:          prdata = '0;
        endcase
    end

    generate
        if (DELAY_DEPTH > MAX_DELAY) begin : g_direct
            for (genvar t = 0; t < TAPS; t++) begin : g_tap
                assign tap_delay[t] = AW'(delay_reg[t]);
            end
        end else begin : g_reduce
            // delay mod depth: reciprocal estimate, one correction step
            localparam int          PW    = DELAY_WIDTH + 32;
            localparam logic [31:0] RECIP = 32'((64'd1 << 32) / DELAY_DEPTH);

            logic [TAPS-1:0][PW-1:0] prod_reg;
            logic [TAPS-1:0][AW-1:0] rem_reg;

            for (genvar t = 0; t < TAPS; t++) begin : g_tap
                logic [DELAY_WIDTH-1:0] quo;
                logic [31:0]            qd;
                logic [31:0]            rem;
                logic [31:0]            rem_fix;

                always_ff @(posedge aclk) begin
                    prod_reg[t] <= PW'(delay_reg[t]) * PW'(RECIP);
                end

                always_comb begin
                    quo     = prod_reg[t][PW-1 -: DELAY_WIDTH];
                    qd      = 32'(quo) * 32'(DELAY_DEPTH);
                    rem     = 32'(delay_reg[t]) - qd;
                    rem_fix = (rem >= 32'(DELAY_DEPTH)) ? rem - 32'(DELAY_DEPTH) : rem;
                end

                always_ff @(posedge aclk) begin
                    rem_reg[t] <= AW'(rem_fix);
                end

                assign tap_delay[t] = rem_reg[t];
            end
        end
    endgenerate

endmodule

`default_nettype wire

@@ rtl/core/tad_mix.sv @@
`timescale 1ns / 1ps
`default_nettype none

module tad_mix (
    input  wire logic                                              aclk,
    input  wire logic                                              aresetn,
    input  wire logic                                              in_valid,
    output logic                                                   in_ready,
    input  wire tad_pkg::tap_ctl_t                                 in_ctl,
    input  wire logic [tad_pkg::TAPS-1:0][tad_pkg::SAMPLE_WIDTH-1:0] tap_q,
    input  wire tad_pkg::cfg_t                                     cfg,
    output logic                                                   out_valid,
    input  wire logic                                              out_ready,
    output tad_pkg::out_beat_t                                     out_data
);

    import tad_pkg::*;

    localparam int DIV_SHIFT  = SUM_WIDTH + 1;
    localparam int PROD_WIDTH = SUM_WIDTH + DIV_SHIFT;
    // ceil(2^DIV_SHIFT / 3): exact floor division for magnitudes below 2^(SUM_WIDTH-1)
    localparam logic [DIV_SHIFT-1:0] DIV_RECIP =
        DIV_SHIFT'(((64'd1 << DIV_SHIFT) + 64'd2) / 64'd3);
    localparam logic signed [SUM_WIDTH-1:0] SAT_MAX =
        {{(SUM_WIDTH - SAMPLE_WIDTH + 1){1'b0}}, {(SAMPLE_WIDTH - 1){1'b1}}};
    localparam logic signed [SUM_WIDTH-1:0] SAT_MIN =
        {{(SUM_WIDTH - SAMPLE_WIDTH + 1){1'b1}}, {(SAMPLE_WIDTH - 1){1'b0}}};

    typedef struct packed {
        logic                           channel;
        logic                           in_range;
        logic signed [SAMPLE_WIDTH-1:0] dry;
        logic signed [SAMPLE_WIDTH-1:0] wet1;
    } side_t;

    logic                          v1_reg, v2_reg, v3_reg, out_valid_reg;
    logic                          rdy1, rdy2, rdy3, rdy_out;
    tap_ctl_t                      ctl1_reg;
    side_t                         side2_reg, side3_reg;
    logic signed [SUM_WIDTH-1:0]   sum2_reg;
    logic [SUM_WIDTH-1:0]          quot3_reg;
    logic                          neg3_reg;
    out_beat_t                     out_data_reg;

    logic signed [SAMPLE_WIDTH-1:0] tap_val [TAPS];
    logic signed [SUM_WIDTH-1:0]    tap_sum;
    side_t                          side1;
    logic                           sum_neg;
    logic [SUM_WIDTH-1:0]           sum_mag;
    logic [PROD_WIDTH-1:0]          div_prod;
    logic signed [SUM_WIDTH-1:0]    quot_s;
    logic signed [SUM_WIDTH-1:0]    mix_sum;
    logic signed [SAMPLE_WIDTH-1:0] wet;
    logic signed [SAMPLE_WIDTH-1:0] result;

    // each stage takes a beat when empty or when its own beat moves on
    assign rdy_out  = !out_valid_reg || out_ready;
    assign rdy3     = !v3_reg || rdy_out;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    // stage 1: tap select (memory data lines up with ctl1_reg) and sum
    always_comb begin
        tap_sum = '0;
        for (int t = 0; t < TAPS; t++) begin
            if (ctl1_reg.fwd[t]) begin
                tap_val[t] = ctl1_reg.dry;
            end else if (ctl1_reg.blank[t]) begin
                tap_val[t] = '0;
            end else begin
                tap_val[t] = tap_q[t];
            end
            tap_sum = tap_sum + SUM_WIDTH'(tap_val[t]);
        end
        side1.channel  = ctl1_reg.channel;
        side1.in_range = ctl1_reg.in_range;
        side1.dry      = ctl1_reg.dry;
        side1.wet1     = tap_val[0];
    end

    // stage 2: divide by three, truncating toward zero on the magnitude
    always_comb begin
        sum_neg  = sum2_reg[SUM_WIDTH-1];
        sum_mag  = sum_neg ? $unsigned(-sum2_reg) : $unsigned(sum2_reg);
        div_prod = PROD_WIDTH'(sum_mag) * PROD_WIDTH'(DIV_RECIP);
    end

    // stage 3: add dry, saturate, pick the mode
    always_comb begin
        quot_s  = neg3_reg ? -$signed(quot3_reg) : $signed(quot3_reg);
        mix_sum = quot_s + SUM_WIDTH'(side3_reg.dry);
        if (mix_sum > SAT_MAX) begin
            wet = SAT_MAX[SAMPLE_WIDTH-1:0];
        end else if (mix_sum < SAT_MIN) begin
            wet = SAT_MIN[SAMPLE_WIDTH-1:0];
        end else begin
            wet = mix_sum[SAMPLE_WIDTH-1:0];
        end
        if (cfg.bypass || !side3_reg.in_range) begin
            result = side3_reg.dry;
        end else if (cfg.multi_mode) begin
            result = wet;
        end else begin
            result = side3_reg.wet1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (rdy1) begin
                v1_reg <= in_valid;
            end
            if (rdy2) begin
                v2_reg <= v1_reg;
            end
            if (rdy3) begin
                v3_reg <= v2_reg;
            end
            if (rdy_out) begin
                out_valid_reg <= v3_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy1 && in_valid) begin
            ctl1_reg <= in_ctl;
        end
        if (rdy2 && v1_reg) begin
            sum2_reg  <= tap_sum;
            side2_reg <= side1;
        end
        if (rdy3 && v2_reg) begin
            quot3_reg <= div_prod[PROD_WIDTH-1 -: SUM_WIDTH];
            neg3_reg  <= sum_neg;
            side3_reg <= side2_reg;
        end
        if (rdy_out && v3_reg) begin
            out_data_reg.channel_out <= side3_reg.channel;
            out_data_reg.sample_out  <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

@@ rtl/core/three_tap_audio_delay_core.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Three-tap audio delay core.
// s_ channel: one beat = channel number and signed sample. The sample is written into
// that channel's circular delay memory and three taps are read back at the configured
// delays. m_ channel: one result beat per input beat, in order, same channel number.
// A beat taken passes four registers: memory read, tap sum, divide by three, and
// mix and saturate. Throughput: one beat per clock while m_ready is high and no
// delay is settling. Each tap has its own copy of the delay memory, all copies
// written together, so the three reads use three single read ports.
// APB port: five 32-bit registers at byte offsets 0x00..0x10, pready tied high.
// A tap delay is reduced modulo the memory depth in a registered unit, so a settle
// counter holds s_ready low after each register write and after reset.
// Reset clears the registers, write positions and pipeline valids. The delay memory
// is not swept: a per-channel write position and wrap flag mark entries not yet
// written, which read as zero, so only the settle counter delays s_ready after reset.
// When m_ready is low the pipeline stages hold their beats; s_ready stays high
// until every stage is full, unless a delay is settling.

module three_tap_audio_delay_core #(
    parameter int CHANNELS    = 2,
    parameter int DELAY_DEPTH = 65536
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  s_valid,
    output logic                                       s_ready,
    input  wire tad_pkg::in_beat_t                     s_data,
    output logic                                       m_valid,
    input  wire logic                                  m_ready,
    output tad_pkg::out_beat_t                         m_data,
    input  wire logic                                  psel,
    input  wire logic                                  penable,
    input  wire logic                                  pwrite,
    input  wire logic [tad_pkg::APB_ADDR_WIDTH-1:0]    paddr,
    input  wire logic [tad_pkg::APB_DATA_WIDTH-1:0]    pwdata,
    output logic [tad_pkg::APB_DATA_WIDTH-1:0]         prdata,
    output logic                                       pready
);

    import tad_pkg::*;

    localparam int AW           = $clog2(DELAY_DEPTH);
    localparam int MEM_DEPTH    = CHANNELS * DELAY_DEPTH;
    localparam int MAW          = $clog2(MEM_DEPTH);
    localparam bit ALL_CH_VALID = (CHANNELS > 1);

    apb_req_t                     apb;
    cfg_t                         cfg;
    logic [TAPS-1:0][AW-1:0]      tap_delay;
    logic                         cfg_busy;
    logic                         mix_ready;
    logic                         accept;
    logic                         in_range;

    // write position and wrap flag per channel
    logic [AW-1:0]                wr_pos_reg [CHANNELS];
    logic [CHANNELS-1:0]          wrapped_reg;
    logic [AW-1:0]                pos_sel;
    logic [AW-1:0]                wr_pos_next;
    logic                         wrapped_sel;
    logic                         pos_last;

    logic [MAW-1:0]               ch_base;
    logic [MAW-1:0]               wr_addr;
    logic [TAPS-1:0][MAW-1:0]     rd_addr;
    logic [TAPS-1:0][SAMPLE_WIDTH-1:0] tap_q;
    tap_ctl_t                     issue_ctl;

    assign apb.psel    = psel;
    assign apb.penable = penable;
    assign apb.pwrite  = pwrite;
    assign apb.paddr   = paddr;
    assign apb.pwdata  = pwdata;
    assign pready      = 1'b1;

    tad_regs #(
        .DELAY_DEPTH (DELAY_DEPTH)
    ) u_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .apb       (apb),
        .prdata    (prdata),
        .cfg       (cfg),
        .tap_delay (tap_delay),
        .busy      (cfg_busy)
    );

    // the input channel field is one bit wide, so only a single-channel build
    // can see a channel out of range
    assign in_range = ALL_CH_VALID || (s_data.channel == 1'b0);
    assign s_ready  = mix_ready && !cfg_busy;
    assign accept   = s_valid && s_ready;

    always_comb begin
        pos_sel     = '0;
        wrapped_sel = 1'b0;
        for (int c = 0; c < CHANNELS; c++) begin
            if (c == int'(s_data.channel)) begin
                pos_sel     = wr_pos_reg[c];
                wrapped_sel = wrapped_reg[c];
            end
        end
    end

    assign pos_last    = pos_sel == AW'(DELAY_DEPTH - 1);
    assign wr_pos_next = pos_last ? '0 : pos_sel + 1'b1;
    assign ch_base     = s_data.channel ? MAW'(DELAY_DEPTH) : '0;
    assign wr_addr     = ch_base + MAW'(pos_sel);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int c = 0; c < CHANNELS; c++) begin
                wr_pos_reg[c] <= '0;
            end
            wrapped_reg <= '0;
        end else if (accept && in_range) begin
            for (int c = 0; c < CHANNELS; c++) begin
                if (c == int'(s_data.channel)) begin
                    wr_pos_reg[c] <= wr_pos_next;
                    if (pos_last) begin
                        wrapped_reg[c] <= 1'b1;
                    end
                end
            end
        end
    end

    // Tap addresses. A zero delay hits the entry being written this cycle, so
    // the dry sample is forwarded instead. Before a channel wraps, entries at or
    // beyond its write position were never written and read as zero.
    always_comb begin
        logic [AW:0] idx_wide;
        issue_ctl.channel  = s_data.channel;
        issue_ctl.in_range = in_range;
        issue_ctl.dry      = s_data.sample_in;
        for (int t = 0; t < TAPS; t++) begin
            if (pos_sel >= tap_delay[t]) begin
                idx_wide = {1'b0, pos_sel} - {1'b0, tap_delay[t]};
            end else begin
                idx_wide = {1'b0, pos_sel} + (AW + 1)'(DELAY_DEPTH) - {1'b0, tap_delay[t]};
            end
            rd_addr[t]         = ch_base + MAW'(idx_wide[AW-1:0]);
            issue_ctl.fwd[t]   = tap_delay[t] == '0;
            issue_ctl.blank[t] = !wrapped_sel && (idx_wide[AW-1:0] >= pos_sel)
                                 && (tap_delay[t] != '0);
        end
    end

    generate
        for (genvar t = 0; t < TAPS; t++) begin : g_mem
            tad_ram #(
                .WIDTH (SAMPLE_WIDTH),
                .DEPTH (MEM_DEPTH)
            ) u_ram (
                .clk     (aclk),
                .wr_en   (accept && in_range),
                .wr_addr (wr_addr),
                .wr_data (s_data.sample_in),
                .rd_en   (accept),
                .rd_addr (rd_addr[t]),
                .rd_data (tap_q[t])
            );
        end
    endgenerate

    tad_mix u_mix (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid && !cfg_busy),
        .in_ready  (mix_ready),
        .in_ctl    (issue_ctl),
        .tap_q     (tap_q),
        .cfg       (cfg),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (m_data)
    );

`ifndef ASSERT_OFF
    // channel 0 position steps by one, wrapping at the depth, per beat taken
    a_pos_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (s_data.channel == 1'b0)) |=>
        (wr_pos_reg[0] == (($past(wr_pos_reg[0]) == AW'(DELAY_DEPTH - 1)) ?
                           '0 : $past(wr_pos_reg[0]) + 1'b1)))
        else $error("write position of channel 0 did not advance by one");

    // once channel 0 has filled its memory, its wrap flag stays set
    a_wrap_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        wrapped_reg[0] |=> wrapped_reg[0])
        else $error("fill flag of channel 0 cleared outside reset");

    // a register write holds off input beats while the reduced delays settle
    a_cfg_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (psel && penable && pwrite) |=> !s_ready)
        else $error("input taken right after a register write");
`endif

endmodule

`default_nettype wire

@@ test/tb.sv @@
`timescale 1ns / 1ps

module tb;
    import tad_pkg::*;

    // Signed sample limits for the mix saturation
    localparam int SMAX = (1 << (SAMPLE_WIDTH - 1)) - 1;
    localparam int SMIN = -SMAX - 1;
    localparam int DEPTH = 65536;

    // ------------------------------------------------------------------
    // Clock, reset and the block's ports
    // ------------------------------------------------------------------
    logic aclk = 1'b0;
    logic aresetn;

    logic      s_valid;
    logic      s_ready;
    in_beat_t  s_data;
    logic      m_valid;
    logic      m_ready;
    out_beat_t m_data;

    logic                      psel;
    logic                      penable;
    logic                      pwrite;
    logic [APB_ADDR_WIDTH-1:0] paddr;
    logic [APB_DATA_WIDTH-1:0] pwdata;
    logic [APB_DATA_WIDTH-1:0] prdata;
    logic                      pready;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    three_tap_audio_delay_core DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // ------------------------------------------------------------------
    // Shadow of the block: delay memories, write pointers and registers.
    // bit types start at zero, which matches unwritten entries reading as zero.
    // ------------------------------------------------------------------
    bit signed [SAMPLE_WIDTH-1:0] echo_mem [2][DEPTH];
    bit [DELAY_WIDTH-1:0]         wr_pos [2];
    bit                           cfg_multi;
    bit                           cfg_bypass;
    bit [DELAY_WIDTH-1:0]         cfg_dly [TAPS];

    out_beat_t expected_out [$];

    int errors;
    int samples_sent;
    int results_checked;
    int sat_hits;
    int bypass_beats;
    int three_tap_beats;

    // Idling switches, read by the source task and the sink process
    bit src_gaps;
    bit sink_stalls;

    // Work out the result of one sample and update the shadow memory.
    // Tap addresses are 16-bit differences, so they wrap round the depth.
    function automatic out_beat_t compute_echo(input logic ch,
                                               input logic signed [SAMPLE_WIDTH-1:0] dry);
        logic [DELAY_WIDTH-1:0] wp;
        int t1, t2, t3, mix;
        out_beat_t r;
        wp = wr_pos[ch];
        echo_mem[ch][wp] = dry;
        mix = dry;
        if (cfg_bypass) begin
            bypass_beats++;
        end else begin
            t1 = echo_mem[ch][16'(wp - cfg_dly[0])];
            if (cfg_multi) begin
                t2 = echo_mem[ch][16'(wp - cfg_dly[1])];
                t3 = echo_mem[ch][16'(wp - cfg_dly[2])];
                // int division truncates toward zero
                mix = (t1 + t2 + t3) / 3 + int'(dry);
                if (mix > SMAX || mix < SMIN) sat_hits++;
                if (mix > SMAX) mix = SMAX;
                if (mix < SMIN) mix = SMIN;
                three_tap_beats++;
            end else begin
                mix = t1;
            end
        end
        wr_pos[ch] = wp + 16'd1;
        r.channel_out = ch;
        r.sample_out  = mix[SAMPLE_WIDTH-1:0];
        return r;
    endfunction

    function automatic logic [31:0] shadow_reg(input reg_idx_t idx);
        case (idx)
            REG_MULTI_MODE:   return {31'd0, cfg_multi};
            REG_BYPASS:       return {31'd0, cfg_bypass};
            REG_FIRST_DELAY:  return {16'd0, cfg_dly[0]};
            REG_SECOND_DELAY: return {16'd0, cfg_dly[1]};
            REG_THIRD_DELAY:  return {16'd0, cfg_dly[2]};
            default:          return 32'd0;
        endcase
    endfunction

    // Full-range noise half the time, else rail, near-rail or tiny values
    function automatic logic signed [SAMPLE_WIDTH-1:0] pick_sample();
        int v;
        v = $urandom_range(0, 16) - 8;
        case ($urandom_range(0, 7))
            0:       return 24'sh7FFFFF;
            1:       return 24'sh800000;
            2:       return 24'(v);
            3:       return 24'sh7FFFFF - 24'($urandom_range(0, 255));
            default: return 24'($urandom);
        endcase
    endfunction

    // Short delays are the useful ones: they land on samples already written
    function automatic logic [DELAY_WIDTH-1:0] pick_delay();
        case ($urandom_range(0, 9))
            0:       return 16'd0;
            1:       return 16'hFFFF;
            2:       return 16'($urandom);
            3:       return 16'hFFFF - 16'($urandom_range(0, 15));
            default: return 16'($urandom_range(1, 48));
        endcase
    endfunction

    // ------------------------------------------------------------------
    // APB access: setup cycle, then access cycle; pready ends the access.
    // An idle cycle follows so back-to-back calls never double-drive psel.
    // ------------------------------------------------------------------
    task automatic apb_access(input logic wr, input reg_idx_t idx,
                              input logic [31:0] wval, output logic [31:0] rval);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= wval;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        rval = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_reg(input reg_idx_t idx, input logic [31:0] val);
        logic [31:0] unused;
        apb_access(1'b1, idx, val, unused);
        case (idx)
            REG_MULTI_MODE:   cfg_multi  = val[0];
            REG_BYPASS:       cfg_bypass = val[0];
            REG_FIRST_DELAY:  cfg_dly[0] = val[15:0];
            REG_SECOND_DELAY: cfg_dly[1] = val[15:0];
            REG_THIRD_DELAY:  cfg_dly[2] = val[15:0];
            default: ;
        endcase
    endtask

    task automatic check_reg(input reg_idx_t idx);
        logic [31:0] got;
        apb_access(1'b0, idx, 32'd0, got);
        if (got !== shadow_reg(idx)) begin
            $display("%0t: readback %s expected %0h, got %0h",
                     $time, idx.name(), shadow_reg(idx), got);
            errors++;
        end
    endtask

    task automatic apply_settings(input bit multi, input bit byp,
                                  input logic [15:0] d1, input logic [15:0] d2,
                                  input logic [15:0] d3);
        set_reg(REG_MULTI_MODE, {31'd0, multi});
        set_reg(REG_BYPASS, {31'd0, byp});
        set_reg(REG_FIRST_DELAY, {16'd0, d1});
        set_reg(REG_SECOND_DELAY, {16'd0, d2});
        set_reg(REG_THIRD_DELAY, {16'd0, d3});
    endtask

    // ------------------------------------------------------------------
    // Source side. s_valid stays high between back-to-back beats; it is only
    // dropped when a gap is taken or when the pipe is drained.
    // ------------------------------------------------------------------
    task automatic send_sample(input logic ch, input logic signed [SAMPLE_WIDTH-1:0] smp);
        if (src_gaps && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= '{channel: ch, sample_in: smp};
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        // beat taken at this edge
        expected_out.push_back(compute_echo(ch, smp));
        samples_sent++;
    endtask

    // Registers may only change with the pipe empty; one result per beat,
    // so an empty queue plus a wait covering the pipeline depth is enough.
    task automatic wait_for_drain();
        s_valid <= 1'b0;
        while (expected_out.size() != 0) @(posedge aclk);
        repeat (6) @(posedge aclk);
    endtask

    // ------------------------------------------------------------------
    // Sink side: bursts of back-pressure, interleaved with ready runs
    // ------------------------------------------------------------------
    initial begin : result_sink
        m_ready = 1'b0;
        @(posedge aclk);
        forever begin
            if (sink_stalls && $urandom_range(0, 2) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge aclk);
            end
            m_ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge aclk);
        end
    end

    // Compare each result beat against the oldest prediction
    always @(posedge aclk) begin : result_check
        out_beat_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_out.size() == 0) begin
                $display("%0t: result with nothing expected, ch %0d sample %0d",
                         $time, m_data.channel_out, m_data.sample_out);
                errors++;
            end else begin
                want = expected_out.pop_front();
                if (m_data.channel_out !== want.channel_out) begin
                    $display("%0t: channel_out expected %0d, got %0d",
                             $time, want.channel_out, m_data.channel_out);
                    errors++;
                end
                if (m_data.sample_out !== want.sample_out) begin
                    $display("%0t: sample_out expected %0d, got %0d",
                             $time, want.sample_out, m_data.sample_out);
                    errors++;
                end
                results_checked++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset values read back as zero: single tap at delay 0 echoes the input.
    // Then every register is written, the first delay at its far end, and read back.
    task automatic test_register_access();
        check_reg(REG_MULTI_MODE);
        check_reg(REG_BYPASS);
        check_reg(REG_FIRST_DELAY);
        check_reg(REG_SECOND_DELAY);
        check_reg(REG_THIRD_DELAY);
        send_sample(1'b0, 24'sh123456);
        send_sample(1'b1, 24'sh800000);
        send_sample(1'b0, -24'sd1);
        wait_for_drain();
        apply_settings(1'b1, 1'b1, 16'hFFFF, 16'd0, 16'hA5C3);
        check_reg(REG_MULTI_MODE);
        check_reg(REG_BYPASS);
        check_reg(REG_FIRST_DELAY);
        check_reg(REG_SECOND_DELAY);
        check_reg(REG_THIRD_DELAY);
    endtask

    // First tap alone: zero delay, one-sample delay, and the longest delay,
    // which lands on a slot not yet written.
    task automatic test_single_tap();
        apply_settings(1'b0, 1'b0, 16'd0, 16'd5, 16'd9);
        send_sample(1'b0, 24'sh7FFFFF);
        send_sample(1'b1, 24'sh800000);
        wait_for_drain();
        set_reg(REG_FIRST_DELAY, 32'd1);
        send_sample(1'b0, 24'sd0);
        send_sample(1'b0, -24'sd1);
        wait_for_drain();
        set_reg(REG_FIRST_DELAY, 32'hFFFF);
        send_sample(1'b1, 24'sd1);
        wait_for_drain();
    endtask

    // Three-tap mix: both saturation rails, then small negative sums where
    // division must truncate toward zero.
    task automatic test_three_tap_mix();
        apply_settings(1'b1, 1'b0, 16'd0, 16'd0, 16'd0);
        send_sample(1'b0, 24'sh7FFFFF);
        send_sample(1'b1, 24'sh800000);
        wait_for_drain();
        apply_settings(1'b1, 1'b0, 16'd0, 16'd1, 16'd2);
        send_sample(1'b0, -24'sd1);
        send_sample(1'b0, -24'sd2);
        send_sample(1'b0, 24'sd1);
        send_sample(1'b0, -24'sd4);
        wait_for_drain();
    endtask

    // Bypass in both modes passes the dry sample, yet the memory still fills:
    // the last two beats pick those samples up through the taps.
    task automatic test_bypass();
        apply_settings(1'b0, 1'b1, 16'd1, 16'd2, 16'd3);
        send_sample(1'b0, 24'sh7FFFFF);
        send_sample(1'b1, 24'sh800000);
        wait_for_drain();
        set_reg(REG_MULTI_MODE, 32'd1);
        send_sample(1'b0, -24'sd5);
        send_sample(1'b1, 24'sd7);
        wait_for_drain();
        set_reg(REG_BYPASS, 32'd0);
        send_sample(1'b0, 24'sd100);
        send_sample(1'b1, -24'sd100);
        wait_for_drain();
    endtask

    // Random settings per phase with random samples, idling on both sides
    task automatic test_random_settings(input int phases, input int beats);
        bit multi, byp;
        for (int p = 0; p < phases; p++) begin
            multi = $urandom_range(0, 1);
            byp   = ($urandom_range(0, 4) == 0);
            apply_settings(multi, byp, pick_delay(), pick_delay(), pick_delay());
            for (int i = 0; i < beats; i++)
                send_sample(1'($urandom_range(0, 1)), pick_sample());
            wait_for_drain();
        end
    endtask

    // Tail of the run: beats back to back on both channels through the
    // three-tap mix, short delays next to one that reaches far back.
    // No idling here.
    task automatic test_back_to_back(input int beats);
        src_gaps    = 1'b0;
        sink_stalls = 1'b0;
        apply_settings(1'b1, 1'b0, 16'd1, 16'd7, 16'd300);
        for (int i = 0; i < beats; i++)
            send_sample(1'($urandom_range(0, 1)), pick_sample());
        wait_for_drain();
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin : run_tests
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data  = '0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        src_gaps    = 1'b1;
        sink_stalls = 1'b1;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_register_access();
        test_single_tap();
        test_three_tap_mix();
        test_bypass();
        test_random_settings(6, 260);
        test_back_to_back(170);

        repeat (10) @(posedge aclk);
        if (expected_out.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, expected_out.size());
            errors++;
        end
        $display("%0d samples sent, %0d results checked (%0d three-tap, %0d bypassed)",
                 samples_sent, results_checked, three_tap_beats, bypass_beats);
        $display("%0d mixes saturated; the tail ran back to back with no idling", sat_hits);
        if (errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // Generous cap: the whole run needs well under half of this
    initial begin : watchdog
        #5_000_000;
        $display("timeout at %0t", $time);
        $display("end of test: mismatches");
        $finish;
    end

endmodule
